/* design/rps_pkg.sv */
// ============================================================================
// rps_pkg: shared definitions for the reflow profile sequencer
// Phase codes, register indexes, reset values, setpoints and the structs
// that pass configuration and results between the top level and the core.
// ============================================================================
package rps_pkg;

    // Timing
    localparam int unsigned TICKS_PER_SECOND = 10;
    localparam int unsigned TICK_W           = 4;
    localparam int unsigned HOLD_W           = 4;
    localparam int unsigned SEC_W            = 16;

    // Field widths
    localparam int unsigned TEMP_W   = 11;
    localparam int unsigned LIMIT_W  = 10;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned SETPT_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 32;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PREHEAT = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SOAK    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_REFLOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_COOL    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_SECONDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_TEMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOAK_SECONDS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOAK_TEMP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFLOW_SECONDS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFLOW_TEMP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_TEMP       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS   = 3'd7;

    // Register reset values
    localparam logic [LIMIT_W-1:0] RST_PREHEAT_SECONDS = 10'd120;
    localparam logic [LIMIT_W-1:0] RST_PREHEAT_TEMP    = 10'd145;
    localparam logic [LIMIT_W-1:0] RST_SOAK_SECONDS    = 10'd60;
    localparam logic [LIMIT_W-1:0] RST_SOAK_TEMP       = 10'd175;
    localparam logic [LIMIT_W-1:0] RST_REFLOW_SECONDS  = 10'd30;
    localparam logic [LIMIT_W-1:0] RST_REFLOW_TEMP     = 10'd205;
    localparam logic [LIMIT_W-1:0] RST_COOL_TEMP       = 10'd100;
    localparam logic [HOLD_W-1:0]  RST_HOLDOFF_TICKS   = 4'd10;

    // Heater setpoints per phase
    localparam logic [SETPT_W-1:0] SETPT_OFF     = 8'd0;
    localparam logic [SETPT_W-1:0] SETPT_PREHEAT = 8'd150;
    localparam logic [SETPT_W-1:0] SETPT_SOAK    = 8'd180;
    localparam logic [SETPT_W-1:0] SETPT_REFLOW  = 8'd210;

    typedef struct packed {
        logic [LIMIT_W-1:0] preheat_seconds;
        logic [LIMIT_W-1:0] preheat_temp_limit;
        logic [LIMIT_W-1:0] soak_seconds;
        logic [LIMIT_W-1:0] soak_temp_limit;
        logic [LIMIT_W-1:0] reflow_seconds;
        logic [LIMIT_W-1:0] reflow_temp_limit;
        logic [LIMIT_W-1:0] cool_temp_limit;
        logic [HOLD_W-1:0]  button_holdoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SEC_W-1:0]   seconds_in_phase;
        logic               led_red;
        logic               led_yellow;
        logic               led_green;
        logic [SETPT_W-1:0] heater_setpoint;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

/* design/rps_core.sv */
// ============================================================================
// rps_core: profile state and per-tick step logic
// Holds the phase, tick, seconds, holdoff, latched temperature and setpoint
// registers and computes the result word of the tick being stepped.
// ============================================================================
module rps_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic signed [rps_pkg::TEMP_W-1:0] i_temperature,
    input  logic                             i_button_level_n,
    input  rps_pkg::t_cfg                    i_cfg,
    output rps_pkg::t_result                 o_result
);

    logic [rps_pkg::PHASE_W-1:0]      r_phase,    n_phase;
    logic [rps_pkg::TICK_W-1:0]       r_tick,     n_tick;
    logic [rps_pkg::SEC_W-1:0]        r_seconds,  n_seconds;
    logic [rps_pkg::HOLD_W-1:0]       r_holdoff,  n_holdoff;
    logic signed [rps_pkg::TEMP_W-1:0] r_temp,    n_temp;
    logic [rps_pkg::SETPT_W-1:0]      r_setpt,    n_setpt;

    logic [rps_pkg::TICK_W-1:0]       tick_inc;
    logic                             full_sec;
    logic [rps_pkg::SEC_W-1:0]        sec_cnt;
    logic [rps_pkg::HOLD_W-1:0]       hold_cnt;
    logic                             press_ok;
    logic                             heat_done;
    logic [rps_pkg::LIMIT_W-1:0]      heat_secs;
    logic [rps_pkg::LIMIT_W-1:0]      heat_limit;
    logic [rps_pkg::PHASE_W-1:0]      heat_next;
    logic                             cool_done;

    // Tick, seconds and holdoff counters, temperature latch
    always_comb begin
        tick_inc = r_tick + 1'b1;
        full_sec = (tick_inc >= rps_pkg::TICK_W'(rps_pkg::TICKS_PER_SECOND));
        n_tick   = full_sec ? '0 : tick_inc;
        hold_cnt = (r_holdoff == '1) ? r_holdoff : r_holdoff + 1'b1;
        sec_cnt  = (full_sec && (r_seconds != '1)) ? r_seconds + 1'b1 : r_seconds;
        n_temp   = full_sec ? i_temperature : r_temp;
    end

    // Limits of the heating phase being evaluated
    always_comb begin
        case (r_phase)
            rps_pkg::PH_PREHEAT: begin
                heat_secs  = i_cfg.preheat_seconds;
                heat_limit = i_cfg.preheat_temp_limit;
                heat_next  = rps_pkg::PH_SOAK;
            end
            rps_pkg::PH_SOAK: begin
                heat_secs  = i_cfg.soak_seconds;
                heat_limit = i_cfg.soak_temp_limit;
                heat_next  = rps_pkg::PH_REFLOW;
            end
            default: begin
                heat_secs  = i_cfg.reflow_seconds;
                heat_limit = i_cfg.reflow_temp_limit;
                heat_next  = rps_pkg::PH_COOL;
            end
        endcase
    end

    assign press_ok  = (hold_cnt >= i_cfg.button_holdoff_ticks) && !i_button_level_n;
    assign heat_done = (sec_cnt >= {{(rps_pkg::SEC_W-rps_pkg::LIMIT_W){1'b0}}, heat_secs})
                    && (n_temp >= $signed({1'b0, heat_limit}));
    assign cool_done = (n_temp < $signed({1'b0, i_cfg.cool_temp_limit}));

    // Profile state machine, one evaluation per tick
    always_comb begin
        n_phase   = r_phase;
        n_seconds = sec_cnt;
        n_holdoff = hold_cnt;
        n_setpt   = r_setpt;
        case (r_phase)
            rps_pkg::PH_IDLE: begin
                n_setpt = rps_pkg::SETPT_OFF;
                if (press_ok) begin
                    n_holdoff = '0;
                    n_seconds = '0;
                    n_phase   = rps_pkg::PH_PREHEAT;
                end
            end
            rps_pkg::PH_PREHEAT, rps_pkg::PH_SOAK, rps_pkg::PH_REFLOW: begin
                case (r_phase)
                    rps_pkg::PH_PREHEAT: n_setpt = rps_pkg::SETPT_PREHEAT;
                    rps_pkg::PH_SOAK:    n_setpt = rps_pkg::SETPT_SOAK;
                    default:             n_setpt = rps_pkg::SETPT_REFLOW;
                endcase
                if (heat_done) begin
                    n_seconds = '0;
                    n_phase   = heat_next;
                end else if (press_ok) begin
                    n_holdoff = '0;
                    n_phase   = rps_pkg::PH_IDLE;
                end
            end
            rps_pkg::PH_COOL: begin
                n_setpt = rps_pkg::SETPT_OFF;
                if (cool_done) begin
                    n_seconds = '0;
                    n_phase   = rps_pkg::PH_DONE;
                end else if (press_ok) begin
                    n_holdoff = '0;
                    n_phase   = rps_pkg::PH_IDLE;
                end
            end
            rps_pkg::PH_DONE: begin
                if (press_ok) begin
                    n_holdoff = '0;
                    n_phase   = rps_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = rps_pkg::PH_IDLE;
            end
        endcase
    end

    // Result word of this tick
    always_comb begin
        o_result.phase            = n_phase;
        o_result.heater_setpoint  = n_setpt;
        o_result.led_green        = 1'b1;
        o_result.led_yellow       = (r_phase >= rps_pkg::PH_PREHEAT)
                                 && (r_phase <= rps_pkg::PH_COOL);
        o_result.led_red          = 1'b0;
        o_result.seconds_in_phase = n_seconds;
    end

    // Commit state on each stepped tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rps_pkg::PH_IDLE;
            r_tick    <= '0;
            r_seconds <= '0;
            r_holdoff <= '0;
            r_temp    <= '0;
            r_setpt   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_seconds <= n_seconds;
            r_holdoff <= n_holdoff;
            r_temp    <= n_temp;
            r_setpt   <= n_setpt;
        end
    end

endmodule

/* design/reflow_profile_sequencer.sv */
// ============================================================================
// reflow_profile_sequencer: solder reflow profile controller
// An input word passes through the input register, then the step logic into
// the result register. Throughput one word per cycle while the output is not
// stalled; the profile state updates once per tick. Synchronous active-low
// reset clears the profile state, loads the default configuration and
// empties both registers; no clearing pass is needed.
// ============================================================================
module reflow_profile_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [10:0] temperature (signed), [11] button_level_n, [15:12] zero
    input  logic [rps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] phase, [10:3] heater_setpoint, [11] led_green, [12] led_yellow,
    // [13] led_red, [29:14] seconds_in_phase, [31:30] zero
    output logic [rps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned RES_W = $bits(rps_pkg::t_result);

    rps_pkg::t_cfg                      r_cfg;
    logic                               r_in_valid;
    logic signed [rps_pkg::TEMP_W-1:0]  r_in_temp;
    logic                               r_in_button;
    logic                               r_out_valid;
    rps_pkg::t_result                   r_out;
    rps_pkg::t_result                   step_result;
    logic                               advance;

    // Move the held word forward whenever the result register can take it
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preheat_seconds      <= rps_pkg::RST_PREHEAT_SECONDS;
            r_cfg.preheat_temp_limit   <= rps_pkg::RST_PREHEAT_TEMP;
            r_cfg.soak_seconds         <= rps_pkg::RST_SOAK_SECONDS;
            r_cfg.soak_temp_limit      <= rps_pkg::RST_SOAK_TEMP;
            r_cfg.reflow_seconds       <= rps_pkg::RST_REFLOW_SECONDS;
            r_cfg.reflow_temp_limit    <= rps_pkg::RST_REFLOW_TEMP;
            r_cfg.cool_temp_limit      <= rps_pkg::RST_COOL_TEMP;
            r_cfg.button_holdoff_ticks <= rps_pkg::RST_HOLDOFF_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rps_pkg::REG_PREHEAT_SECONDS: r_cfg.preheat_seconds    <= i_cfg_data;
                rps_pkg::REG_PREHEAT_TEMP:    r_cfg.preheat_temp_limit <= i_cfg_data;
                rps_pkg::REG_SOAK_SECONDS:    r_cfg.soak_seconds       <= i_cfg_data;
                rps_pkg::REG_SOAK_TEMP:       r_cfg.soak_temp_limit    <= i_cfg_data;
                rps_pkg::REG_REFLOW_SECONDS:  r_cfg.reflow_seconds     <= i_cfg_data;
                rps_pkg::REG_REFLOW_TEMP:     r_cfg.reflow_temp_limit  <= i_cfg_data;
                rps_pkg::REG_COOL_TEMP:       r_cfg.cool_temp_limit    <= i_cfg_data;
                rps_pkg::REG_HOLDOFF_TICKS:
                    r_cfg.button_holdoff_ticks <= i_cfg_data[rps_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the word until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_temp   <= $signed(s_axis_tdata[rps_pkg::TEMP_W-1:0]);
            r_in_button <= s_axis_tdata[rps_pkg::TEMP_W];
        end
    end

    rps_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_temperature    (r_in_temp),
        .i_button_level_n (r_in_button),
        .i_cfg            (r_cfg),
        .o_result         (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rps_pkg::OUT_DATA_W-RES_W){1'b0}}, r_out};

endmodule
